// ===== rtl/core/srg_pkg.sv =====
package srg_pkg;

	localparam int LEN_WIDTH = 24;

	typedef struct packed {
		logic accept;
		logic eval;
		logic div_step;
		logic mul;
		logic sum;
		logic load_out;
	} srg_cmd_t;

	typedef struct packed {
		logic done;
		logic div_last;
		logic out_free;
	} srg_status_t;

endpackage

// ===== rtl/core/srg_in_if.sv =====
interface srg_in_if #(
	parameter int TIME_WIDTH  = 32,
	parameter int LEVEL_WIDTH = 24
);
	logic                                  valid;
	logic                                  ready;
	logic        [TIME_WIDTH-1:0]          now_tick;
	logic        [srg_pkg::LEN_WIDTH-1:0]  length_ticks;
	logic signed [LEVEL_WIDTH-1:0]         start_level;
	logic signed [LEVEL_WIDTH-1:0]         end_level;

	modport source (
		output valid, now_tick, length_ticks, start_level, end_level,
		input  ready
	);
	modport sink (
		input  valid, now_tick, length_ticks, start_level, end_level,
		output ready
	);
endinterface

// ===== rtl/core/srg_out_if.sv =====
interface srg_out_if #(
	parameter int LEVEL_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [LEVEL_WIDTH-1:0] level_out;
	logic                          segment_done;

	modport source (
		output valid, level_out, segment_done,
		input  ready
	);
	modport sink (
		input  valid, level_out, segment_done,
		output ready
	);
endinterface

// ===== rtl/core/srg_ctrl.sv =====
module srg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  srg_pkg::srg_status_t status,
	output srg_pkg::srg_cmd_t    cmd
);
	import srg_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EVAL  = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_SUM   = 6'b010000,
		ST_WRITE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = status.done ? ST_WRITE : ST_DIV;
			end
			ST_DIV: begin
				if (status.div_last) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign cmd.accept   = (state_q == ST_IDLE) && item_valid;
	assign cmd.eval     = (state_q == ST_EVAL);
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.mul      = (state_q == ST_MUL);
	assign cmd.sum      = (state_q == ST_SUM);
	assign cmd.load_out = (state_q == ST_WRITE) && status.out_free;

endmodule

// ===== rtl/core/srg_datapath.sv =====
module srg_datapath #(
	parameter int TIME_WIDTH    = 32,
	parameter int LEVEL_WIDTH   = 24,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  srg_pkg::srg_cmd_t                    cmd,
	output srg_pkg::srg_status_t                 status,
	input  logic        [TIME_WIDTH-1:0]         now_tick,
	input  logic        [srg_pkg::LEN_WIDTH-1:0] length_ticks,
	input  logic signed [LEVEL_WIDTH-1:0]        start_level,
	input  logic signed [LEVEL_WIDTH-1:0]        end_level,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [LEVEL_WIDTH-1:0]        level_out,
	output logic                                 segment_done
);
	import srg_pkg::*;

	localparam int CMPW = (TIME_WIDTH > LEN_WIDTH) ? TIME_WIDTH : LEN_WIDTH;
	localparam int CW   = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;
	localparam int MW   = LEVEL_WIDTH + 1;
	localparam int PW   = MW + FRACTION_BITS;

	logic        [TIME_WIDTH-1:0]    now_q;
	logic        [TIME_WIDTH-1:0]    begin_q;
	logic        [LEN_WIDTH-1:0]     len_q;
	logic                            finished_q;
	logic signed [LEVEL_WIDTH-1:0]   start_q;
	logic signed [LEVEL_WIDTH-1:0]   end_q;
	logic                            done_q;
	logic        [LEN_WIDTH:0]       rem_q;
	logic        [FRACTION_BITS-1:0] frac_q;
	logic        [CW-1:0]            cnt_q;
	logic        [MW-1:0]            mag_q;
	logic                            neg_q;
	logic        [PW-1:0]            prod_q;
	logic        [LEVEL_WIDTH-1:0]   level_q;
	logic                            out_valid_q;
	logic        [LEVEL_WIDTH-1:0]   out_level_q;
	logic                            out_done_q;

	logic [TIME_WIDTH-1:0] elapsed;
	logic [CMPW-1:0]       elapsed_ext;
	logic                  done_now;
	logic [LEN_WIDTH:0]    rem_sh;
	logic                  rem_ge;
	logic signed [MW-1:0]  diff;
	logic [MW-1:0]         step_mag;
	logic [MW-1:0]         start_ext;
	logic [MW-1:0]         level_sum;

	assign elapsed     = now_q - begin_q;
	assign elapsed_ext = CMPW'(elapsed);
	assign done_now    = (elapsed_ext >= CMPW'(len_q));

	assign rem_sh = {rem_q[LEN_WIDTH-1:0], 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, len_q});

	assign diff      = $signed({end_q[LEVEL_WIDTH-1], end_q})
	                 - $signed({start_q[LEVEL_WIDTH-1], start_q});
	assign step_mag  = prod_q[PW-1:FRACTION_BITS];
	assign start_ext = {start_q[LEVEL_WIDTH-1], start_q};
	assign level_sum = neg_q ? (start_ext - step_mag) : (start_ext + step_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q    <= '0;
			len_q      <= '0;
			finished_q <= 1'b1;
		end else begin
			if (cmd.accept && finished_q) begin
				begin_q <= now_tick;
				len_q   <= length_ticks;
			end
			if (cmd.eval) begin
				finished_q <= done_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			now_q   <= now_tick;
			start_q <= start_level;
			end_q   <= end_level;
		end
		if (cmd.eval) begin
			done_q <= done_now;
			rem_q  <= {1'b0, elapsed_ext[LEN_WIDTH-1:0]};
			frac_q <= '0;
			cnt_q  <= '0;
			neg_q  <= diff[MW-1];
			mag_q  <= diff[MW-1] ? MW'(-diff) : MW'(diff);
		end
		if (cmd.div_step) begin
			rem_q  <= rem_ge ? (rem_sh - {1'b0, len_q}) : rem_sh;
			frac_q <= {frac_q[FRACTION_BITS-2:0], rem_ge};
			cnt_q  <= cnt_q + 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= PW'(mag_q) * PW'(frac_q);
		end
		if (cmd.sum) begin
			level_q <= level_sum[LEVEL_WIDTH-1:0];
		end
		if (cmd.load_out) begin
			out_level_q <= done_q ? end_q : level_q;
			out_done_q  <= done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.done     = done_now;
	assign status.div_last = (cnt_q == CW'(FRACTION_BITS - 1));
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign level_out    = out_level_q;
	assign segment_done = out_done_q;

endmodule

// ===== rtl/core/segment_ramp_generator_unit.sv =====
// Linear ramp envelope segment. Each input word carries the current tick, a segment
// length and start/end levels; when the previous segment has ended a new one starts
// from that tick. The result word is the level interpolated by the elapsed fraction
// (clamped to 0..1) plus a done flag once the segment end is reached. One word is in
// work at a time: a word that ends its segment goes from accept through an evaluate
// step straight to the output load; any other passes from evaluate through the
// bit-serial restoring divider, which forms the fraction one bit per cycle, then a
// multiply step and an add step to the output load. The load waits while the output
// register still holds a result not yet taken. The result sits in an output register,
// so a new word is accepted while a finished result still waits downstream.
module segment_ramp_generator_unit #(
	parameter int TIME_WIDTH    = 32,
	parameter int LEVEL_WIDTH   = 24,
	parameter int FRACTION_BITS = 16
) (
	input logic     clk,
	input logic     arst_n,
	srg_in_if.sink  item,
	srg_out_if.source result
);
	import srg_pkg::*;

	srg_cmd_t    cmd;
	srg_status_t status;

	srg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	srg_datapath #(
		.TIME_WIDTH    (TIME_WIDTH),
		.LEVEL_WIDTH   (LEVEL_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.now_tick     (item.now_tick),
		.length_ticks (item.length_ticks),
		.start_level  (item.start_level),
		.end_level    (item.end_level),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.level_out    (result.level_out),
		.segment_done (result.segment_done)
	);

endmodule
